### src/cst_pkg.sv
package cst_pkg;

  localparam int MAX_TOKEN_LENGTH = 4096;
  localparam int COUNT_W = 13;
  localparam int LINE_W = 16;
  localparam int MAX_RESULTS = 3;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    END_OPEN      = 3'd0,
    END_SEMI      = 3'd1,
    END_CLOSE     = 3'd2,
    END_EOF       = 3'd3,
    END_EOF_EMPTY = 3'd4,
    END_LIMIT     = 3'd5
  } end_code_t;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } out_kind_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    out_kind_t         out_kind;
    logic [7:0]        out_char;
    end_code_t         end_code;
    logic [LINE_W-1:0] line_number;
    logic              last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic               block_comment;
    logic               star_seen;
    logic               slash_held;
    logic               quoted;
    logic               line_comment;
    logic [COUNT_W-1:0] token_count;
    logic [LINE_W-1:0]  line_count;
  } tok_state_t;

  typedef struct packed {
    out_beat_t [MAX_RESULTS-1:0] res;
    logic [1:0]                  num;
  } step_out_t;

endpackage

### src/comment_stripping_tokenizer.sv
// Character tokenizer with comment stripping. One byte enters per cycle on the
// in channel when not stalled; each byte yields zero to three result beats
// (token characters and delimiter-coded token ends), held in a three-entry
// result queue that drains one beat per cycle unless out stalls. A byte is
// taken in the cycle the queue empties, so the rate is one byte per cycle
// while each byte gives at most one beat and out is not stalled; else a byte
// waits for the previous byte's beats to drain. The last beat of each byte
// carries last_of_run; line_number (line count after it) saturates at 65535.
module comment_stripping_tokenizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cst_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cst_pkg::out_beat_t  out_data
);

  cst_pkg::tok_state_t state;
  cst_pkg::tok_state_t state_next;
  cst_pkg::step_out_t  step;
  cst_pkg::out_beat_t [cst_pkg::MAX_RESULTS-1:0] queue;
  logic [1:0] cnt;
  logic       pop;
  logic       accept;

  cst_step u_step (
    .cur  (state),
    .beat (in_data),
    .nxt  (state_next),
    .step (step)
  );

  assign out_valid = (cnt != 2'd0);
  assign out_data  = queue[0];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((cnt == 2'd0) || (cnt == 2'd1 && !out_stall));
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{line_count: cst_pkg::LINE_W'(1), default: '0};
      cnt <= 2'd0;
    end else if (accept) begin
      state <= state_next;
      cnt <= step.num;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue <= step.res;
    end else if (pop) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
    end
  end

  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, state.token_count} < (cst_pkg::COUNT_W + 1)'(cst_pkg::MAX_TOKEN_LENGTH))
    else $error("token count reached limit");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.line_count != '0)
    else $error("line count is zero");

  a_last_beat_flag: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1) |-> out_data.last_of_run)
    else $error("final queued beat lacks last_of_run");

  a_earlier_not_last: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> !out_data.last_of_run)
    else $error("last_of_run set before final beat");

endmodule

### src/cst_step.sv
module cst_step (
  input  cst_pkg::tok_state_t cur,
  input  cst_pkg::in_beat_t   beat,
  output cst_pkg::tok_state_t nxt,
  output cst_pkg::step_out_t  step
);

  localparam logic [cst_pkg::COUNT_W:0] LIMIT = (cst_pkg::COUNT_W + 1)'(cst_pkg::MAX_TOKEN_LENGTH);

  logic [7:0]              c;
  logic [cst_pkg::COUNT_W:0] cnt1;
  logic [cst_pkg::COUNT_W:0] cnt2;
  logic                    newline;

  assign c = beat.in_char;
  assign cnt1 = {1'b0, cur.token_count} + 1'b1;
  assign cnt2 = {1'b0, cur.token_count} + 2'd2;

  function automatic cst_pkg::out_beat_t mk_char(input logic [7:0] ch);
    cst_pkg::out_beat_t b;
    b = '0;
    b.out_kind = cst_pkg::KIND_CHAR;
    b.out_char = ch;
    b.end_code = cst_pkg::END_OPEN;
    return b;
  endfunction

  function automatic cst_pkg::out_beat_t mk_end(input cst_pkg::end_code_t code);
    cst_pkg::out_beat_t b;
    b = '0;
    b.out_kind = cst_pkg::KIND_END;
    b.end_code = code;
    return b;
  endfunction

  function automatic cst_pkg::tok_state_t cleared(input cst_pkg::tok_state_t s);
    cst_pkg::tok_state_t t;
    t = '0;
    t.line_count = s.line_count;
    return t;
  endfunction

  always_comb begin
    nxt = cur;
    step = '0;
    newline = 1'b0;
    if (beat.end_of_input) begin
      step.res[0] = mk_end((cur.token_count != '0) ? cst_pkg::END_EOF : cst_pkg::END_EOF_EMPTY);
      step.num = 2'd1;
      nxt = cleared(cur);
    end else if (cur.line_comment) begin
      if (c == cst_pkg::CH_NL) begin
        nxt.line_comment = 1'b0;
        newline = 1'b1;
      end
    end else if (cur.block_comment) begin
      if (c == cst_pkg::CH_SLASH && cur.star_seen) begin
        nxt.block_comment = 1'b0;
        nxt.star_seen = 1'b0;
      end else begin
        nxt.star_seen = (c == cst_pkg::CH_STAR);
      end
    end else if (!cur.quoted && (c == cst_pkg::CH_SPACE || c == cst_pkg::CH_TAB)) begin
      nxt = cur;
    end else if (c == cst_pkg::CH_QUOTE) begin
      nxt.quoted = !cur.quoted;
    end else if (c == cst_pkg::CH_SLASH) begin
      nxt.slash_held = !cur.slash_held;
      nxt.line_comment = cur.slash_held;
    end else if (c == cst_pkg::CH_STAR && cur.slash_held) begin
      nxt.slash_held = 1'b0;
      nxt.block_comment = 1'b1;
      nxt.star_seen = 1'b0;
    end else if (c == cst_pkg::CH_NL) begin
      newline = 1'b1;
    end else if (c == cst_pkg::CH_OPEN) begin
      step.res[0] = mk_end(cst_pkg::END_OPEN);
      step.num = 2'd1;
      nxt = cleared(cur);
    end else if (c == cst_pkg::CH_SEMI) begin
      step.res[0] = mk_end(cst_pkg::END_SEMI);
      step.num = 2'd1;
      nxt = cleared(cur);
    end else if (c == cst_pkg::CH_CLOSE) begin
      step.res[0] = mk_end(cst_pkg::END_CLOSE);
      step.num = 2'd1;
      nxt = cleared(cur);
    end else if (cur.slash_held) begin
      step.res[0] = mk_char(cst_pkg::CH_SLASH);
      step.num = 2'd3;
      if (cnt1 >= LIMIT) begin
        // held slash fills the token, the character opens the next one
        step.res[1] = mk_end(cst_pkg::END_LIMIT);
        step.res[2] = mk_char(c);
        nxt = cleared(cur);
        nxt.token_count = cst_pkg::COUNT_W'(1);
      end else if (cnt2 >= LIMIT) begin
        step.res[1] = mk_char(c);
        step.res[2] = mk_end(cst_pkg::END_LIMIT);
        nxt = cleared(cur);
      end else begin
        step.res[1] = mk_char(c);
        step.num = 2'd2;
        nxt.slash_held = 1'b0;
        nxt.token_count = cnt2[cst_pkg::COUNT_W-1:0];
      end
    end else begin
      step.res[0] = mk_char(c);
      if (cnt1 >= LIMIT) begin
        step.res[1] = mk_end(cst_pkg::END_LIMIT);
        step.num = 2'd2;
        nxt = cleared(cur);
      end else begin
        step.num = 2'd1;
        nxt.token_count = cnt1[cst_pkg::COUNT_W-1:0];
      end
    end

    if (newline && cur.line_count != '1) begin
      nxt.line_count = cur.line_count + 1'b1;
    end

    for (int i = 0; i < cst_pkg::MAX_RESULTS; i++) begin
      step.res[i].line_number = nxt.line_count;
      step.res[i].last_of_run = (2'(i + 1) == step.num);
    end
  end

endmodule

### dv/tb_comment_stripping_tokenizer.sv
module tb_comment_stripping_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cst_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cst_pkg::out_beat_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_bytes = 0;
  int errors = 0;

  // tokenizer state as seen by the prediction
  logic                        in_block_cmt = 1'b0;
  logic                        star_pending = 1'b0;
  logic                        slash_pending = 1'b0;
  logic                        in_quotes = 1'b0;
  logic                        in_line_cmt = 1'b0;
  logic [cst_pkg::COUNT_W-1:0] token_len = '0;
  logic [cst_pkg::LINE_W-1:0]  line_no = cst_pkg::LINE_W'(1);

  cst_pkg::out_beat_t byte_beats[$];
  cst_pkg::out_beat_t expected_beats[$];

  always #5 clk = ~clk;

  comment_stripping_tokenizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic void add_beat(cst_pkg::out_kind_t kind, logic [7:0] ch,
                                   cst_pkg::end_code_t code);
    cst_pkg::out_beat_t b;
    b.out_kind    = kind;
    b.out_char    = ch;
    b.end_code    = code;
    b.line_number = line_no;
    b.last_of_run = 1'b0;
    byte_beats.push_back(b);
  endfunction

  function automatic void end_token(cst_pkg::end_code_t code);
    add_beat(cst_pkg::KIND_END, 8'h00, code);
    in_block_cmt  = 1'b0;
    star_pending  = 1'b0;
    slash_pending = 1'b0;
    in_quotes     = 1'b0;
    in_line_cmt   = 1'b0;
    token_len     = '0;
  endfunction

  function automatic void token_char(logic [7:0] ch);
    add_beat(cst_pkg::KIND_CHAR, ch, cst_pkg::END_OPEN);
    token_len = token_len + 1'b1;
    if (token_len >= cst_pkg::MAX_TOKEN_LENGTH) begin
      end_token(cst_pkg::END_LIMIT);
    end
  endfunction

  function automatic void bump_line();
    if (line_no != '1) begin
      line_no = line_no + 1'b1;
    end
  endfunction

  function automatic void tokenize_byte(cst_pkg::in_beat_t b);
    logic [7:0] c;
    c = b.in_char;
    byte_beats.delete();
    if (b.end_of_input) begin
      end_token(token_len != 0 ? cst_pkg::END_EOF : cst_pkg::END_EOF_EMPTY);
    end else if (in_line_cmt) begin
      if (c == cst_pkg::CH_NL) begin
        in_line_cmt = 1'b0;
        bump_line();
      end
    end else if (in_block_cmt) begin
      if (c == cst_pkg::CH_SLASH && star_pending) begin
        in_block_cmt = 1'b0;
        star_pending = 1'b0;
      end else begin
        star_pending = (c == cst_pkg::CH_STAR);
      end
    end else if (!in_quotes && (c == cst_pkg::CH_SPACE || c == cst_pkg::CH_TAB)) begin
      // whitespace outside quotes is dropped
    end else if (c == cst_pkg::CH_QUOTE) begin
      in_quotes = !in_quotes;
    end else if (c == cst_pkg::CH_SLASH) begin
      if (slash_pending) begin
        slash_pending = 1'b0;
        in_line_cmt   = 1'b1;
      end else begin
        slash_pending = 1'b1;
      end
    end else if (c == cst_pkg::CH_STAR && slash_pending) begin
      slash_pending = 1'b0;
      in_block_cmt  = 1'b1;
      star_pending  = 1'b0;
    end else if (c == cst_pkg::CH_NL) begin
      bump_line();
    end else if (c == cst_pkg::CH_OPEN) begin
      end_token(cst_pkg::END_OPEN);
    end else if (c == cst_pkg::CH_SEMI) begin
      end_token(cst_pkg::END_SEMI);
    end else if (c == cst_pkg::CH_CLOSE) begin
      end_token(cst_pkg::END_CLOSE);
    end else begin
      if (slash_pending) begin
        slash_pending = 1'b0;
        token_char(cst_pkg::CH_SLASH);
      end
      token_char(c);
    end
    if (byte_beats.size() > 0) begin
      byte_beats[byte_beats.size()-1].last_of_run = 1'b1;
    end
    foreach (byte_beats[i]) begin
      expected_beats.push_back(byte_beats[i]);
    end
  endfunction

  task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  task automatic check_beat(cst_pkg::out_beat_t got);
    cst_pkg::out_beat_t exp;
    if (expected_beats.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got %h", $time, got);
      errors++;
    end else begin
      exp = expected_beats.pop_front();
      compare_field("out_kind", 16'(exp.out_kind), 16'(got.out_kind));
      compare_field("out_char", 16'(exp.out_char), 16'(got.out_char));
      compare_field("end_code", 16'(exp.end_code), 16'(got.end_code));
      compare_field("line_number", exp.line_number, got.line_number);
      compare_field("last_of_run", 16'(exp.last_of_run), 16'(got.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      tokenize_byte(in_data);
    end
    if (!rst && out_valid && !out_stall) begin
      check_beat(out_data);
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic send_beat(logic [7:0] ch, logic eoi);
    cst_pkg::in_beat_t b;
    b.in_char      = ch;
    b.end_of_input = eoi;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_char(logic [7:0] ch);
    send_beat(ch, 1'b0);
  endtask

  task automatic send_eoi();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) begin
      send_char(s[i]);
    end
  endtask

  function automatic logic [7:0] plain_char();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  task automatic test_delimiters();
    send_text("ab{");
    send_char(cst_pkg::CH_SEMI);
    send_text("c}");
    send_char(8'hFF);
    send_char(8'h00);
    send_char(cst_pkg::CH_SEMI);
    send_char(8'h80);
    send_eoi();
    send_eoi();
  endtask

  task automatic test_comments();
    // newline inside a block comment is not counted
    send_text("a/*x*\n*/b;");
    send_text("//c{\nd");
    // held slash survives space, quote and newline
    send_text("/ \"\n\te\"");
    send_text("/;");
    // delimiter and comment inside quotes
    send_text("\"x /*y*/ ;");
    send_text("/*z");
    send_eoi();
    send_text("//w");
    send_eoi();
  endtask

  task automatic test_random_text(int n);
    int kind;
    int len;
    int d;
    int stop;
    stop = sent_bytes + n;
    while (sent_bytes < stop) begin
      kind = $urandom_range(0, 11);
      len  = $urandom_range(0, 4);
      case (kind)
        0, 1, 2: begin
          repeat (len + 1) send_char(plain_char());
        end
        3: begin
          send_text("/*");
          repeat (len) send_char($urandom_range(0, 2) == 0 ? cst_pkg::CH_STAR
                                                            : 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 4) == 0) begin
            send_eoi();
          end else begin
            send_text("*/");
          end
        end
        4: begin
          send_text("//");
          repeat (len) send_char(plain_char());
          if ($urandom_range(0, 4) == 0) begin
            send_eoi();
          end else begin
            send_char(cst_pkg::CH_NL);
          end
        end
        5: begin
          send_char(cst_pkg::CH_QUOTE);
          repeat (len) send_char($urandom_range(0, 2) == 0 ? cst_pkg::CH_SPACE : plain_char());
          send_char(cst_pkg::CH_QUOTE);
        end
        6, 7: begin
          d = $urandom_range(0, 2);
          send_char(d == 0 ? cst_pkg::CH_OPEN : (d == 1 ? cst_pkg::CH_SEMI : cst_pkg::CH_CLOSE));
        end
        8: begin
          d = $urandom_range(0, 2);
          send_char(d == 0 ? cst_pkg::CH_SPACE : (d == 1 ? cst_pkg::CH_TAB : cst_pkg::CH_NL));
        end
        9: begin
          send_char(cst_pkg::CH_SLASH);
          if ($urandom_range(0, 1) == 0) begin
            send_char(cst_pkg::CH_SPACE);
          end
          send_char(plain_char());
        end
        10: begin
          send_char(8'($urandom_range(0, 255)));
        end
        default: begin
          send_eoi();
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 59;
    test_delimiters();
    test_comments();
    test_random_text(65);

    send_idle_pct = 59;
    recv_idle_pct = 35;
    test_random_text(65);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(65);

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/cst_pkg.sv
src/cst_step.sv
src/comment_stripping_tokenizer.sv
dv/tb_comment_stripping_tokenizer.sv
